// File: design/htbr_pkg.sv
// shared types and constants for the ranked histogram report block
// no dependencies

package htbr_pkg;

    localparam int CMD_W    = 2;
    localparam int IDX_W    = 6;
    localparam int CNT_W    = 16;
    localparam int RANK_W   = 7;
    localparam int MINROW_W = 7;
    localparam logic [MINROW_W-1:0] MIN_ROWS_RST = 7'd5;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_MOST  = 2'd1,
        CMD_LEAST = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_END
    } t_state;

    // compare unit controls and results
    typedef struct packed {
        logic desc;
        logic have_cur;
        logic have_best;
    } t_cmp_ctl;

    typedef struct packed {
        logic eq;
        logic better;
    } t_cmp_res;

endpackage

// File: design/htbr_store.sv
// bin count memory with per-entry valid bits cleared at reset
// uses htbr_pkg only through its parameters from the top level

module htbr_store #(
    parameter int NUM_BINS   = 64,
    parameter int COUNT_BITS = 16,
    parameter int AW         = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  logic [COUNT_BITS-1:0] i_wdata,
    input  logic                  i_re,
    input  logic [AW-1:0]         i_raddr,
    output logic [COUNT_BITS-1:0] o_rdata
);

    logic [COUNT_BITS-1:0] r_mem [NUM_BINS];
    logic [NUM_BINS-1:0]   r_vld;
    logic [COUNT_BITS-1:0] r_q;
    logic                  r_ok;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_ok  <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_ok <= r_vld[i_raddr];
            end
        end
    end

    assign o_rdata = r_ok ? r_q : '0;

endmodule

// File: design/htbr_cmp.sv
// shared compare unit: match against current value, track next best value
// depends on htbr_pkg

module htbr_cmp #(
    parameter int COUNT_BITS = 16
) (
    input  htbr_pkg::t_cmp_ctl    i_ctl,
    input  logic [COUNT_BITS-1:0] i_val,
    input  logic [COUNT_BITS-1:0] i_cur,
    input  logic [COUNT_BITS-1:0] i_best,
    output htbr_pkg::t_cmp_res    o_res
);

    import htbr_pkg::*;

    logic cand;
    logic beats;

    always_comb begin
        cand  = !i_ctl.have_cur || (i_ctl.desc ? (i_val < i_cur) : (i_val > i_cur));
        beats = !i_ctl.have_best || (i_ctl.desc ? (i_val > i_best) : (i_val < i_best));
        o_res.eq     = i_ctl.have_cur && (i_val == i_cur);
        o_res.better = cand && beats;
    end

endmodule

// File: design/histogram_top_bottom_rank.sv
// ranked histogram report: sequencer, pending row and output register
// depends on htbr_pkg, htbr_store, htbr_cmp
//
// channel | signals                                   | dir
// input   | i_valid o_ready i_command i_bin_index i_bin_count | in
// output  | o_valid i_ready o_rank o_row_bin o_row_count o_last_row | out
// config  | i_cfg_we i_cfg_data                       | in
//
// a load is written to the memory on acceptance, so loads can follow each other every cycle while idle
// a report runs one pass over the memory per reported value, plus one leading pass to
// find the first value; each pass reads every bin through the single read port
// reset clears all bins at once through per-bin valid bits and sets min_rows to 5
// a stalled output freezes the scan; o_ready is low while a report runs

module histogram_top_bottom_rank #(
    parameter int NUM_BINS   = 64,
    parameter int COUNT_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [htbr_pkg::MINROW_W-1:0]  i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [htbr_pkg::CMD_W-1:0]     i_command,
    input  logic [htbr_pkg::IDX_W-1:0]     i_bin_index,
    input  logic [htbr_pkg::CNT_W-1:0]     i_bin_count,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [htbr_pkg::RANK_W-1:0]    o_rank,
    output logic [htbr_pkg::IDX_W-1:0]     o_row_bin,
    output logic [htbr_pkg::CNT_W-1:0]     o_row_count,
    output logic                           o_last_row
);

    import htbr_pkg::*;

    localparam int AW = $clog2(NUM_BINS);
    localparam int RW = $clog2(NUM_BINS + 1);
    localparam int CW = (RW > MINROW_W) ? RW : MINROW_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_BINS - 1);

    t_state r_state, n_state;
    logic [MINROW_W-1:0]   r_min_rows;
    logic [AW-1:0]         r_addr, n_addr;
    logic                  r_rd_vld;
    logic [AW-1:0]         r_rd_idx;
    logic                  r_desc, n_desc;
    logic                  r_have_cur, n_have_cur;
    logic                  r_have_best, n_have_best;
    logic [COUNT_BITS-1:0] r_cur, n_cur;
    logic [COUNT_BITS-1:0] r_best, n_best;
    logic [RW-1:0]         r_rank, n_rank;
    logic [RW-1:0]         r_rows, n_rows;
    logic                  r_pend_vld, n_pend_vld;
    logic [RW-1:0]         r_pend_rank, n_pend_rank;
    logic [AW-1:0]         r_pend_idx, n_pend_idx;
    logic [COUNT_BITS-1:0] r_pend_cnt, n_pend_cnt;
    logic                  r_out_vld, n_out_vld;
    logic [RW-1:0]         r_out_rank, n_out_rank;
    logic [AW-1:0]         r_out_idx, n_out_idx;
    logic [COUNT_BITS-1:0] r_out_cnt, n_out_cnt;
    logic                  r_out_last, n_out_last;

    logic                  stall;
    logic                  accept;
    logic                  load_we;
    logic                  rd_en;
    logic [8:0]            idx_w;
    logic [31:0]           cnt_w;
    logic [COUNT_BITS-1:0] rd_data;
    t_cmp_ctl              cmp_ctl;
    t_cmp_res              cmp_res;
    logic                  stop;
    logic [8:0]            out_idx_w;
    logic [31:0]           out_cnt_w;
    logic [31:0]           out_rank_w;

    assign stall  = r_out_vld && !i_ready;
    assign o_ready = (r_state == S_IDLE);
    assign accept = i_valid && o_ready;
    assign idx_w  = 9'(i_bin_index);
    assign cnt_w  = 32'(i_bin_count);
    assign load_we = accept && (t_cmd'(i_command) == CMD_LOAD) && (idx_w < 9'(NUM_BINS));
    assign rd_en  = (r_state == S_SCAN) && !stall;

    htbr_store #(
        .NUM_BINS   (NUM_BINS),
        .COUNT_BITS (COUNT_BITS),
        .AW         (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (load_we),
        .i_waddr (idx_w[AW-1:0]),
        .i_wdata (cnt_w[COUNT_BITS-1:0]),
        .i_re    (rd_en),
        .i_raddr (r_addr),
        .o_rdata (rd_data)
    );

    assign cmp_ctl.desc      = r_desc;
    assign cmp_ctl.have_cur  = r_have_cur;
    assign cmp_ctl.have_best = r_have_best;

    htbr_cmp #(
        .COUNT_BITS (COUNT_BITS)
    ) u_cmp (
        .i_ctl  (cmp_ctl),
        .i_val  (rd_data),
        .i_cur  (r_cur),
        .i_best (r_best),
        .o_res  (cmp_res)
    );

    assign stop = !r_have_best || (r_have_cur && (CW'(r_rows) >= CW'(r_min_rows)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_min_rows <= MIN_ROWS_RST;
            r_rd_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
            if (i_cfg_we) begin
                r_min_rows <= i_cfg_data;
            end
            if (!stall) begin
                r_rd_vld <= (r_state == S_SCAN);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_idx <= r_addr;
        end
        r_addr      <= n_addr;
        r_desc      <= n_desc;
        r_have_cur  <= n_have_cur;
        r_have_best <= n_have_best;
        r_cur       <= n_cur;
        r_best      <= n_best;
        r_rank      <= n_rank;
        r_rows      <= n_rows;
        r_pend_rank <= n_pend_rank;
        r_pend_idx  <= n_pend_idx;
        r_pend_cnt  <= n_pend_cnt;
        r_out_rank  <= n_out_rank;
        r_out_idx   <= n_out_idx;
        r_out_cnt   <= n_out_cnt;
        r_out_last  <= n_out_last;
    end

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_desc      = r_desc;
        n_have_cur  = r_have_cur;
        n_have_best = r_have_best;
        n_cur       = r_cur;
        n_best      = r_best;
        n_rank      = r_rank;
        n_rows      = r_rows;
        n_pend_vld  = r_pend_vld;
        n_pend_rank = r_pend_rank;
        n_pend_idx  = r_pend_idx;
        n_pend_cnt  = r_pend_cnt;
        n_out_vld   = r_out_vld && !i_ready;
        n_out_rank  = r_out_rank;
        n_out_idx   = r_out_idx;
        n_out_cnt   = r_out_cnt;
        n_out_last  = r_out_last;

        // one memory word through the compare unit
        if (r_rd_vld && !stall) begin
            if (cmp_res.eq) begin
                n_rows = r_rows + RW'(1);
                if (r_pend_vld) begin
                    n_out_vld  = 1'b1;
                    n_out_rank = r_pend_rank;
                    n_out_idx  = r_pend_idx;
                    n_out_cnt  = r_pend_cnt;
                    n_out_last = 1'b0;
                end
                n_pend_vld  = 1'b1;
                n_pend_rank = r_rank;
                n_pend_idx  = r_rd_idx;
                n_pend_cnt  = rd_data;
            end
            if (cmp_res.better) begin
                n_best      = rd_data;
                n_have_best = 1'b1;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept && ((t_cmd'(i_command) == CMD_MOST) ||
                               (t_cmd'(i_command) == CMD_LEAST)) &&
                    (r_min_rows != '0)) begin
                    n_desc      = (t_cmd'(i_command) == CMD_MOST);
                    n_have_cur  = 1'b0;
                    n_have_best = 1'b0;
                    n_rank      = '0;
                    n_rows      = '0;
                    n_addr      = '0;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!stall) begin
                    n_addr = r_addr + AW'(1);
                    if (r_addr == LAST_ADDR) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                if (!stall) begin
                    n_state = S_END;
                end
            end
            S_END: begin
                if (!stall) begin
                    if (stop) begin
                        if (r_pend_vld) begin
                            n_out_vld  = 1'b1;
                            n_out_rank = r_pend_rank;
                            n_out_idx  = r_pend_idx;
                            n_out_cnt  = r_pend_cnt;
                            n_out_last = 1'b1;
                        end
                        n_pend_vld = 1'b0;
                        n_state    = S_IDLE;
                    end else begin
                        n_cur       = r_best;
                        n_have_cur  = 1'b1;
                        n_have_best = 1'b0;
                        n_rank      = r_rank + RW'(1);
                        n_addr      = '0;
                        n_state     = S_SCAN;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign out_idx_w  = 9'(r_out_idx);
    assign out_cnt_w  = 32'(r_out_cnt);
    assign out_rank_w = 32'(r_out_rank);

    assign o_valid     = r_out_vld;
    assign o_rank      = out_rank_w[RANK_W-1:0];
    assign o_row_bin   = out_idx_w[IDX_W-1:0];
    assign o_row_count = out_cnt_w[CNT_W-1:0];
    assign o_last_row  = r_out_last;

    // idle means nothing left in the pending row
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !r_pend_vld)
        else $error("pending row left at idle");

    // a row that is not the last is always followed by a pending one
    a_more_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_row) |-> r_pend_vld)
        else $error("non-final row without a follower");

    // the final row leaves no pending row behind
    a_last_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_row) |-> !r_pend_vld || !o_ready)
        else $error("final row with pending row at idle");

    // row count never passes the number of bins
    a_rows_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (32'(r_rows) <= NUM_BINS))
        else $error("row count overflow");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for the ranked histogram report block histogram_top_bottom_rank
// depends on htbr_pkg and the block's rtl; keeps its own bin table and predicts every row

module testbench;

    import htbr_pkg::*;

    localparam int NUM_BINS    = 64;
    localparam int DRAIN_PAUSE = 4 * (NUM_BINS + 2);
    localparam int CYCLE_LIMIT = 6_000_000;
    localparam int SEGMENTS    = 3;
    localparam int SEG_ITEMS   = 30;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [IDX_W-1:0]  bin;
        logic [CNT_W-1:0]  count;
        logic              last;
    } t_row;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_we    = 1'b0;
    logic [MINROW_W-1:0] i_cfg_data  = '0;
    logic                i_valid     = 1'b0;
    logic [CMD_W-1:0]    i_command   = CMD_LOAD;
    logic [IDX_W-1:0]    i_bin_index = '0;
    logic [CNT_W-1:0]    i_bin_count = '0;
    logic                i_ready     = 1'b0;
    logic                o_ready;
    logic                o_valid;
    logic [RANK_W-1:0]   o_rank;
    logic [IDX_W-1:0]    o_row_bin;
    logic [CNT_W-1:0]    o_row_count;
    logic                o_last_row;

    logic [CNT_W-1:0]    bin_table [NUM_BINS];
    logic [MINROW_W-1:0] row_limit;
    t_row                ranked_rows [$];
    t_row                head_row;
    int                  fault_count   = 0;
    int                  cycle_count   = 0;
    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;

    histogram_top_bottom_rank u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_command   (i_command),
        .i_bin_index (i_bin_index),
        .i_bin_count (i_bin_count),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_rank      (o_rank),
        .o_row_bin   (o_row_bin),
        .o_row_count (o_row_count),
        .o_last_row  (o_last_row)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic void note_fault(string msg);
        if (fault_count < 10) begin
            $display("%s", msg);
        end
        fault_count++;
    endfunction

    // rows of one report: whole groups of equal counts until row_limit is reached
    function automatic void rank_report(t_cmd cmd);
        logic             desc;
        logic             have_prev;
        logic             got;
        logic [CNT_W-1:0] cur;
        logic [CNT_W-1:0] best;
        int               rows;
        int               rank;
        int               b;
        t_row             row;
        desc      = (cmd == CMD_MOST);
        have_prev = 1'b0;
        cur       = '0;
        rows      = 0;
        rank      = 0;
        while (rows < int'(row_limit)) begin
            got  = 1'b0;
            best = '0;
            for (b = 0; b < NUM_BINS; b++) begin
                if (have_prev && (desc ? bin_table[b] >= cur : bin_table[b] <= cur)) begin
                    continue;
                end
                if (!got || (desc ? bin_table[b] > best : bin_table[b] < best)) begin
                    best = bin_table[b];
                    got  = 1'b1;
                end
            end
            if (!got) begin
                break;
            end
            cur       = best;
            have_prev = 1'b1;
            rank++;
            for (b = 0; b < NUM_BINS; b++) begin
                if (bin_table[b] == cur) begin
                    row.rank  = RANK_W'(rank);
                    row.bin   = IDX_W'(b);
                    row.count = cur;
                    row.last  = 1'b0;
                    ranked_rows.push_back(row);
                    rows++;
                end
            end
        end
        if (rows > 0) begin
            row      = ranked_rows.pop_back();
            row.last = 1'b1;
            ranked_rows.push_back(row);
        end
    endfunction

    // result side: random stalls and row checking
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (ranked_rows.size() == 0) begin
                note_fault($sformatf("unexpected row: rank=%0d bin=%0d count=%0d last=%0b",
                                     o_rank, o_row_bin, o_row_count, o_last_row));
            end else begin
                head_row = ranked_rows.pop_front();
                if (o_rank !== head_row.rank || o_row_bin !== head_row.bin ||
                    o_row_count !== head_row.count || o_last_row !== head_row.last) begin
                    note_fault($sformatf(
                        "row mismatch: expected rank=%0d bin=%0d count=%0d last=%0b, got rank=%0d bin=%0d count=%0d last=%0b",
                        head_row.rank, head_row.bin, head_row.count, head_row.last,
                        o_rank, o_row_bin, o_row_count, o_last_row));
                end
            end
        end
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_request(t_cmd cmd, logic [IDX_W-1:0] idx, logic [CNT_W-1:0] cnt);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid     <= 1'b1;
        i_command   <= cmd;
        i_bin_index <= idx;
        i_bin_count <= cnt;
        do @(posedge i_clk); while (!o_ready);
        case (cmd)
            CMD_LOAD: begin
                bin_table[idx] = cnt;
            end
            CMD_MOST, CMD_LEAST: begin
                rank_report(cmd);
            end
            default: begin
            end
        endcase
    endtask

    task automatic drain_rows();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (ranked_rows.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic set_min_rows(logic [MINROW_W-1:0] value);
        drain_rows();
        repeat (DRAIN_PAUSE) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        row_limit = value;
    endtask

    function automatic logic [MINROW_W-1:0] pick_row_limit();
        case ($urandom_range(9))
            0: pick_row_limit = '0;
            1: pick_row_limit = MINROW_W'(NUM_BINS);
            2: pick_row_limit = '1;
            3: pick_row_limit = MINROW_W'($urandom_range(127, 9));
            default: pick_row_limit = MINROW_W'($urandom_range(8, 1));
        endcase
    endfunction

    function automatic logic [CNT_W-1:0] pick_count();
        case ($urandom_range(19))
            0, 1, 2, 3, 4, 5, 6, 7: pick_count = CNT_W'($urandom_range(3));
            8, 9, 10: pick_count = CNT_W'($urandom_range(15));
            11: pick_count = '0;
            12: pick_count = '1;
            default: pick_count = CNT_W'($urandom);
        endcase
    endfunction

    // reset value of min_rows and a cleared table: one tied group of all bins
    task automatic test_cleared_table();
        send_request(CMD_MOST, '0, '0);
        send_request(CMD_LEAST, '1, '1);
    endtask

    task automatic test_count_extremes();
        send_request(CMD_LOAD, 6'd0, 16'hFFFF);
        send_request(CMD_LOAD, 6'd63, 16'h0001);
        send_request(CMD_LOAD, 6'd31, 16'h8000);
        send_request(CMD_LOAD, 6'd10, 16'h8000);
        send_request(CMD_LOAD, 6'd32, 16'h7FFF);
        send_request(CMD_NONE, 6'd5, 16'hFFFF);
        send_request(CMD_MOST, '0, '0);
        send_request(CMD_LEAST, '0, '0);
    endtask

    task automatic test_row_limits();
        set_min_rows('0);
        send_request(CMD_MOST, '0, '0);
        send_request(CMD_LEAST, '0, '0);
        set_min_rows(7'd1);
        send_request(CMD_MOST, '0, '0);
        send_request(CMD_LEAST, '0, '0);
        set_min_rows(MINROW_W'(NUM_BINS));
        send_request(CMD_MOST, '0, '0);
        set_min_rows('1);
        send_request(CMD_LEAST, '0, '0);
    endtask

    task automatic test_random_traffic(int send_pct, int recv_pct);
        int   seg;
        int   n;
        int   pick;
        t_cmd cmd;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (seg = 0; seg < SEGMENTS; seg++) begin
            set_min_rows(pick_row_limit());
            for (n = 0; n < SEG_ITEMS; n++) begin
                if ($urandom_range(99) < 3) begin
                    drain_rows();
                end
                pick = $urandom_range(99);
                if (pick < 70) begin
                    cmd = CMD_LOAD;
                end else if (pick < 84) begin
                    cmd = CMD_MOST;
                end else if (pick < 98) begin
                    cmd = CMD_LEAST;
                end else begin
                    cmd = CMD_NONE;
                end
                send_request(cmd, IDX_W'($urandom_range(NUM_BINS - 1)), pick_count());
            end
        end
    endtask

    initial begin
        foreach (bin_table[b]) begin
            bin_table[b] = '0;
        end
        row_limit = MIN_ROWS_RST;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_cleared_table();
        test_count_extremes();
        test_row_limits();
        test_random_traffic(35, 46);
        test_random_traffic(46, 35);
        test_random_traffic(0, 0);

        drain_rows();
        repeat (DRAIN_PAUSE) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: histogram_top_bottom_rank.f
design/htbr_pkg.sv
design/htbr_store.sv
design/htbr_cmp.sv
design/histogram_top_bottom_rank.sv
verif/testbench.sv
